// ===== hdl/cdt_pkg.sv =====
// cdt_pkg: shared types, codes and helpers for the countdown timer
// no dependencies; compiled first
package cdt_pkg;

    localparam int unsigned CfgIndexWidth = 3;
    localparam int unsigned CfgDataWidth  = 32;
    localparam int unsigned MaxDurWidth   = 24;
    localparam int unsigned SecsWidth     = 32;
    localparam int unsigned PresetWidth   = 31;

    typedef logic [CfgIndexWidth-1:0] cfg_index_t;
    typedef logic [CfgDataWidth-1:0]  cfg_data_t;
    typedef logic [3:0]               req_type_t;
    typedef logic [1:0]               remote_state_t;
    typedef logic [1:0]               timer_status_t;
    typedef logic [MaxDurWidth-1:0]   max_dur_t;
    typedef logic [PresetWidth-1:0]   preset_t;

    // request codes
    localparam req_type_t REQ_TICK         = 4'd0;
    localparam req_type_t REQ_SET_PRESET   = 4'd1;
    localparam req_type_t REQ_START_PRESET = 4'd2;
    localparam req_type_t REQ_START_VALUE  = 4'd3;
    localparam req_type_t REQ_PAUSE        = 4'd4;
    localparam req_type_t REQ_RESUME       = 4'd5;
    localparam req_type_t REQ_CANCEL       = 4'd6;
    localparam req_type_t REQ_REMOTE_STATE = 4'd7;
    localparam req_type_t REQ_REMOTE_REM   = 4'd8;

    // remote state codes
    localparam remote_state_t RS_IDLE   = 2'd0;
    localparam remote_state_t RS_PAUSED = 2'd1;
    localparam remote_state_t RS_ACTIVE = 2'd2;
    localparam remote_state_t RS_OTHER  = 2'd3;

    // reported status codes
    localparam timer_status_t ST_STOPPED         = 2'd0;
    localparam timer_status_t ST_PAUSED          = 2'd1;
    localparam timer_status_t ST_RUNNING_OVERDUE = 2'd2;
    localparam timer_status_t ST_RUNNING         = 2'd3;

    // configuration register indexes
    localparam cfg_index_t CFG_MAX_DURATION   = 3'd0;
    localparam cfg_index_t CFG_SYNC_ENABLE    = 3'd1;
    localparam cfg_index_t CFG_REMOTE_STATE   = 3'd2;
    localparam cfg_index_t CFG_REMOTE_REM     = 3'd3;
    localparam cfg_index_t CFG_SYNC_INTERVAL  = 3'd4;

    // remote reports of half a second or less are ignored (Q24.8)
    localparam logic [31:0] HALF_SECOND_Q8 = 32'd128;

    // negative to zero, above a nonzero maximum to the maximum
    function automatic preset_t clamp_secs(input logic signed [SecsWidth-1:0] s,
                                           input max_dur_t max_dur);
        preset_t res;
        if (s < 0) begin
            res = '0;
        end else if ((max_dur != '0) &&
                     (s > $signed({{(SecsWidth-MaxDurWidth){1'b0}}, max_dur}))) begin
            res = {{(PresetWidth-MaxDurWidth){1'b0}}, max_dur};
        end else begin
            res = s[PresetWidth-1:0];
        end
        return res;
    endfunction

endpackage

// ===== hdl/cdt_cfg_if.sv =====
// cdt_cfg_if: configuration write channel (index and data)
// depends on cdt_pkg
interface cdt_cfg_if;
    import cdt_pkg::*;

    logic       valid;
    logic       ready;
    cfg_index_t index;
    cfg_data_t  data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

// ===== hdl/cdt_req_if.sv =====
// cdt_req_if: request channel carrying one command item per transfer
// depends on cdt_pkg
interface cdt_req_if;
    import cdt_pkg::*;

    logic                 valid;
    logic                 ready;
    req_type_t            req_type;
    logic signed [31:0]   seconds_value;
    remote_state_t        remote_state;
    logic [31:0]          remote_remaining;
    logic [31:0]          now_ms;

    modport source (output valid, output req_type, output seconds_value,
                    output remote_state, output remote_remaining, output now_ms,
                    input ready);
    modport sink (input valid, input req_type, input seconds_value,
                  input remote_state, input remote_remaining, input now_ms,
                  output ready);
endinterface

// ===== hdl/cdt_rsp_if.sv =====
// cdt_rsp_if: result channel carrying count, status and event flags
// depends on cdt_pkg
interface cdt_rsp_if;
    import cdt_pkg::*;

    logic                 valid;
    logic                 ready;
    logic signed [31:0]   remaining_count;
    preset_t              preset_count;
    timer_status_t        timer_status;
    logic                 overdue_flag;
    logic                 synced_flag;
    logic                 ev_started;
    logic                 ev_paused;
    logic                 ev_resumed;
    logic                 ev_cancelled;
    logic                 ev_finished;
    logic                 ev_ticked;
    logic                 ev_from_remote;

    modport source (output valid, output remaining_count, output preset_count,
                    output timer_status, output overdue_flag, output synced_flag,
                    output ev_started, output ev_paused, output ev_resumed,
                    output ev_cancelled, output ev_finished, output ev_ticked,
                    output ev_from_remote, input ready);
    modport sink (input valid, input remaining_count, input preset_count,
                  input timer_status, input overdue_flag, input synced_flag,
                  input ev_started, input ev_paused, input ev_resumed,
                  input ev_cancelled, input ev_finished, input ev_ticked,
                  input ev_from_remote, output ready);
endinterface

// ===== hdl/countdown_timer_with_remote_sync_top.sv =====
// countdown_timer_with_remote_sync_top: seconds countdown timer with remote sync
// the result is registered and valid in the cycle after the request transfer
// throughput: one request per cycle while results are taken; the result register frees as it is taken
// reset (rst_n low, asynchronous): stopped, all counts, marks and registers zero
// depends on cdt_pkg, cdt_cfg_if, cdt_req_if, cdt_rsp_if
module countdown_timer_with_remote_sync_top (
    input  logic          clk,
    input  logic          rst_n,
    cdt_cfg_if.sink       cfg,
    cdt_req_if.sink       req,
    cdt_rsp_if.source     rsp
);
    import cdt_pkg::*;

    typedef enum logic [1:0] {
        PH_STOPPED,
        PH_PAUSED,
        PH_RUNNING
    } phase_t;

    typedef struct packed {
        logic started;
        logic paused;
        logic resumed;
        logic cancelled;
        logic finished;
        logic ticked;
        logic from_remote;
    } ev_t;

    // configuration
    max_dur_t           max_duration_reg;
    logic               sync_enable_reg;
    logic               rs_present_reg;
    logic               rr_present_reg;
    logic [31:0]        sync_interval_reg;

    // timer state
    phase_t             phase_reg, phase_next;
    logic signed [31:0] remaining_reg, remaining_next;
    preset_t            preset_reg, preset_next;
    logic               overdue_reg, overdue_next;
    logic               synced_reg, synced_next;
    logic [31:0]        last_sync_reg, last_sync_next;
    max_dur_t           last_remote_reg, last_remote_next;

    // result register
    logic               valid_reg;
    ev_t                ev_reg, ev_next;

    logic               accept;
    logic               sync_possible;
    logic signed [31:0] rem_dec;
    max_dur_t           rs_state;
    preset_t            rs_start;
    max_dur_t           rs_rem;
    logic [31:0]        elapsed;
    preset_t            clamp_value;
    preset_t            clamp_remote;

    assign cfg.ready = 1'b1;
    assign req.ready = !valid_reg || rsp.ready;
    assign accept    = req.valid && req.ready;

    assign sync_possible = sync_enable_reg && (rs_present_reg || rr_present_reg);
    assign rem_dec = (remaining_reg == 32'sh8000_0000) ? remaining_reg
                                                       : remaining_reg - 32'sd1;
    assign rs_state = rr_present_reg ? last_remote_reg : '0;
    assign rs_start = (rs_state == '0) ? preset_reg
                                       : {{(PresetWidth-MaxDurWidth){1'b0}}, rs_state};
    assign rs_rem   = req.remote_remaining[31:8];
    assign elapsed  = req.now_ms - last_sync_reg;

    // start value for local starts and remote active
    always_comb
    begin
        unique case (req.req_type)
            REQ_START_VALUE:  clamp_value = clamp_secs(req.seconds_value, max_duration_reg);
            REQ_REMOTE_STATE: clamp_value = clamp_secs($signed({1'b0, rs_start}),
                                                       max_duration_reg);
            default:          clamp_value = clamp_secs($signed({1'b0, preset_reg}),
                                                       max_duration_reg);
        endcase
    end

    // remote seconds adopted while stopped
    always_comb
    begin
        if (req.req_type == REQ_REMOTE_REM) begin
            clamp_remote = clamp_secs($signed({8'd0, rs_rem}), max_duration_reg);
        end else begin
            clamp_remote = clamp_secs($signed({8'd0, rs_state}), max_duration_reg);
        end
    end

    always_comb
    begin
        phase_next       = phase_reg;
        remaining_next   = remaining_reg;
        preset_next      = preset_reg;
        overdue_next     = overdue_reg;
        synced_next      = synced_reg;
        last_sync_next   = last_sync_reg;
        last_remote_next = last_remote_reg;
        ev_next          = '0;

        unique case (req.req_type)
            REQ_TICK:
            begin
                if (phase_reg == PH_RUNNING) begin
                    remaining_next = rem_dec;
                    if ((rem_dec <= 0) && !overdue_reg) begin
                        overdue_next     = 1'b1;
                        ev_next.finished = 1'b1;
                    end
                    ev_next.ticked = 1'b1;
                end
            end
            REQ_SET_PRESET:
            begin
                preset_next = clamp_secs(req.seconds_value, max_duration_reg);
            end
            REQ_START_PRESET, REQ_START_VALUE:
            begin
                preset_next     = clamp_value;
                remaining_next  = $signed({1'b0, clamp_value});
                phase_next      = PH_RUNNING;
                overdue_next    = 1'b0;
                synced_next     = sync_possible;
                ev_next.started = 1'b1;
            end
            REQ_PAUSE:
            begin
                if (phase_reg == PH_RUNNING) begin
                    phase_next     = PH_PAUSED;
                    ev_next.paused = 1'b1;
                end
            end
            REQ_RESUME:
            begin
                if (phase_reg == PH_PAUSED) begin
                    phase_next      = PH_RUNNING;
                    synced_next     = sync_possible;
                    ev_next.resumed = 1'b1;
                end
            end
            REQ_CANCEL:
            begin
                phase_next        = PH_STOPPED;
                remaining_next    = '0;
                overdue_next      = 1'b0;
                synced_next       = 1'b0;
                ev_next.cancelled = 1'b1;
            end
            REQ_REMOTE_STATE:
            begin
                if (rs_present_reg && sync_enable_reg) begin
                    synced_next = sync_possible;
                    unique case (req.remote_state)
                        RS_IDLE:
                        begin
                            if ((phase_reg != PH_STOPPED) && (remaining_reg > 0)) begin
                                phase_next          = PH_STOPPED;
                                remaining_next      = '0;
                                overdue_next        = 1'b0;
                                synced_next         = 1'b0;
                                ev_next.cancelled   = 1'b1;
                                ev_next.from_remote = 1'b1;
                            end
                        end
                        RS_PAUSED:
                        begin
                            if (phase_reg == PH_RUNNING) begin
                                phase_next          = PH_PAUSED;
                                ev_next.paused      = 1'b1;
                                ev_next.from_remote = 1'b1;
                            end else if ((phase_reg == PH_STOPPED) && (rs_state != '0)) begin
                                preset_next    = clamp_remote;
                                remaining_next = $signed({8'd0, rs_state});
                                phase_next     = PH_PAUSED;
                                overdue_next   = 1'b0;
                            end
                        end
                        RS_ACTIVE:
                        begin
                            if (phase_reg == PH_PAUSED) begin
                                phase_next          = PH_RUNNING;
                                ev_next.resumed     = 1'b1;
                                ev_next.from_remote = 1'b1;
                            end else if (phase_reg == PH_STOPPED) begin
                                preset_next         = clamp_value;
                                remaining_next      = $signed({1'b0, clamp_value});
                                phase_next          = PH_RUNNING;
                                overdue_next        = 1'b0;
                                ev_next.started     = 1'b1;
                                ev_next.from_remote = 1'b1;
                            end
                        end
                        RS_OTHER:
                        begin
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            REQ_REMOTE_REM:
            begin
                if (rr_present_reg) begin
                    last_remote_next = rs_rem;
                    if (sync_enable_reg) begin
                        synced_next = sync_possible;
                        if (req.remote_remaining > HALF_SECOND_Q8) begin
                            if (phase_reg == PH_STOPPED) begin
                                if (rs_rem != '0) begin
                                    preset_next    = clamp_remote;
                                    remaining_next = $signed({8'd0, rs_rem});
                                    phase_next     = PH_RUNNING;
                                    overdue_next   = 1'b0;
                                end
                            end else if ((elapsed >= sync_interval_reg) && (rs_rem != '0)) begin
                                remaining_next = $signed({8'd0, rs_rem});
                                last_sync_next = req.now_ms;
                            end
                        end
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            max_duration_reg  <= '0;
            sync_enable_reg   <= 1'b0;
            rs_present_reg    <= 1'b0;
            rr_present_reg    <= 1'b0;
            sync_interval_reg <= '0;
        end else if (cfg.valid) begin
            unique case (cfg.index)
                CFG_MAX_DURATION:  max_duration_reg  <= cfg.data[MaxDurWidth-1:0];
                CFG_SYNC_ENABLE:   sync_enable_reg   <= cfg.data[0];
                CFG_REMOTE_STATE:  rs_present_reg    <= cfg.data[0];
                CFG_REMOTE_REM:    rr_present_reg    <= cfg.data[0];
                CFG_SYNC_INTERVAL: sync_interval_reg <= cfg.data;
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg       <= PH_STOPPED;
            remaining_reg   <= '0;
            preset_reg      <= '0;
            overdue_reg     <= 1'b0;
            synced_reg      <= 1'b0;
            last_sync_reg   <= '0;
            last_remote_reg <= '0;
            valid_reg       <= 1'b0;
            ev_reg          <= '0;
        end else if (accept) begin
            phase_reg       <= phase_next;
            remaining_reg   <= remaining_next;
            preset_reg      <= preset_next;
            overdue_reg     <= overdue_next;
            synced_reg      <= synced_next;
            last_sync_reg   <= last_sync_next;
            last_remote_reg <= last_remote_next;
            valid_reg       <= 1'b1;
            ev_reg          <= ev_next;
        end else if (rsp.ready) begin
            valid_reg <= 1'b0;
        end
    end

    // state only moves on a transfer, so the state registers are the result
    always_comb
    begin
        unique case (phase_reg)
            PH_STOPPED: rsp.timer_status = ST_STOPPED;
            PH_PAUSED:  rsp.timer_status = ST_PAUSED;
            default:    rsp.timer_status = overdue_reg ? ST_RUNNING_OVERDUE : ST_RUNNING;
        endcase
    end

    assign rsp.valid           = valid_reg;
    assign rsp.remaining_count = remaining_reg;
    assign rsp.preset_count    = preset_reg;
    assign rsp.overdue_flag    = overdue_reg;
    assign rsp.synced_flag     = synced_reg;
    assign rsp.ev_started      = ev_reg.started;
    assign rsp.ev_paused       = ev_reg.paused;
    assign rsp.ev_resumed      = ev_reg.resumed;
    assign rsp.ev_cancelled    = ev_reg.cancelled;
    assign rsp.ev_finished     = ev_reg.finished;
    assign rsp.ev_ticked       = ev_reg.ticked;
    assign rsp.ev_from_remote  = ev_reg.from_remote;

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// testbench: self-checking bench for countdown_timer_with_remote_sync_top
// drives commands and register writes, predicts each report and compares it
// depends on cdt_pkg, cdt_cfg_if, cdt_req_if, cdt_rsp_if and the top level
module testbench;
    import cdt_pkg::*;

    localparam int unsigned IdleLimit = 5000;
    localparam req_type_t REQ_RESERVED = 4'd15;
    localparam logic signed [31:0] MIN_COUNT = 32'sh8000_0000;

    typedef enum logic [1:0] {PHASE_STOPPED, PHASE_PAUSED, PHASE_RUNNING} run_phase_t;

    typedef struct {
        req_type_t          kind;
        logic signed [31:0] secs;
        remote_state_t      rstate;
        logic [31:0]        rrem;
        logic [31:0]        stamp;
    } timer_cmd_t;

    typedef struct {
        logic signed [31:0] count;
        preset_t            preset;
        timer_status_t      status;
        logic               overdue;
        logic               synced;
        logic               started;
        logic               paused;
        logic               resumed;
        logic               cancelled;
        logic               finished;
        logic               ticked;
        logic               from_remote;
    } timer_report_t;

    typedef logic [31:0] field_row_t [12];

    logic clk = 1'b0;
    logic rst_n;

    cdt_cfg_if cfg_ch();
    cdt_req_if req_ch();
    cdt_rsp_if rsp_ch();

    countdown_timer_with_remote_sync_top i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_ch),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // register copies
    logic [23:0] c_max        = '0;
    logic        c_sync_en    = 1'b0;
    logic        c_rs_present = 1'b0;
    logic        c_rr_present = 1'b0;
    logic [31:0] c_interval   = '0;

    // timer state copies
    run_phase_t         t_phase       = PHASE_STOPPED;
    logic signed [31:0] t_count       = '0;
    preset_t            t_preset      = '0;
    logic               t_overdue     = 1'b0;
    logic               t_synced      = 1'b0;
    logic [31:0]        t_last_sync   = '0;
    logic [23:0]        t_last_remote = '0;

    timer_cmd_t    pending_cmds[$];
    timer_report_t predicted_reports[$];
    int unsigned   cmds_queued     = 0;
    int unsigned   reports_checked = 0;
    int unsigned   mismatch_count  = 0;
    int unsigned   idle_cycles     = 0;
    int unsigned   send_idle_pct   = 0;
    int unsigned   recv_stall_pct  = 0;
    int unsigned   reqs_accepted   = 0;
    int unsigned   reqs_seen       = 0;
    logic [31:0]   ms_clock        = '0;

    string field_names [12] = '{"remaining_count", "preset_count", "timer_status",
        "overdue_flag", "synced_flag", "ev_started", "ev_paused", "ev_resumed",
        "ev_cancelled", "ev_finished", "ev_ticked", "ev_from_remote"};

    function automatic logic [31:0] clamp_seconds(input longint s);
        longint lim;
        lim = longint'(c_max);
        if (s < 0)
            return '0;
        if (c_max != '0 && s > lim)
            return {8'd0, c_max};
        return s[31:0];
    endfunction

    function automatic logic sync_possible();
        return c_sync_en && (c_rs_present || c_rr_present);
    endfunction

    function automatic void start_count(input longint s);
        logic [31:0] v;
        v = clamp_seconds(s);
        t_preset = v[30:0];
        t_count = v;
        t_phase = PHASE_RUNNING;
        t_overdue = 1'b0;
        t_synced = sync_possible();
    endfunction

    function automatic void stop_count();
        t_phase = PHASE_STOPPED;
        t_count = '0;
        t_overdue = 1'b0;
        t_synced = 1'b0;
    endfunction

    // advances the timer copy by one command and returns the report it yields
    function automatic timer_report_t step_timer(input timer_cmd_t c);
        timer_report_t r;
        logic [31:0]   rsec;
        logic [31:0]   since;
        logic [31:0]   v;
        r = '{default: '0};
        case (c.kind)
            REQ_TICK:
                if (t_phase == PHASE_RUNNING)
                begin
                    if (t_count != MIN_COUNT)
                        t_count = t_count - 1;
                    if (t_count <= 0 && !t_overdue)
                    begin
                        t_overdue = 1'b1;
                        r.finished = 1'b1;
                    end
                    r.ticked = 1'b1;
                end
            REQ_SET_PRESET:
            begin
                v = clamp_seconds(longint'(c.secs));
                t_preset = v[30:0];
            end
            REQ_START_PRESET:
            begin
                start_count(longint'(t_preset));
                r.started = 1'b1;
            end
            REQ_START_VALUE:
            begin
                start_count(longint'(c.secs));
                r.started = 1'b1;
            end
            REQ_PAUSE:
                if (t_phase == PHASE_RUNNING)
                begin
                    t_phase = PHASE_PAUSED;
                    r.paused = 1'b1;
                end
            REQ_RESUME:
                if (t_phase == PHASE_PAUSED)
                begin
                    t_phase = PHASE_RUNNING;
                    t_synced = sync_possible();
                    r.resumed = 1'b1;
                end
            REQ_CANCEL:
            begin
                stop_count();
                r.cancelled = 1'b1;
            end
            REQ_REMOTE_STATE:
                if (c_rs_present && c_sync_en)
                begin
                    t_synced = sync_possible();
                    rsec = c_rr_present ? {8'd0, t_last_remote} : 32'd0;
                    case (c.rstate)
                        RS_IDLE:
                            if (t_phase != PHASE_STOPPED && t_count > 0)
                            begin
                                stop_count();
                                r.cancelled = 1'b1;
                                r.from_remote = 1'b1;
                            end
                        RS_PAUSED:
                            if (t_phase == PHASE_RUNNING)
                            begin
                                t_phase = PHASE_PAUSED;
                                r.paused = 1'b1;
                                r.from_remote = 1'b1;
                            end
                            else if (t_phase == PHASE_STOPPED && rsec != 0)
                            begin
                                v = clamp_seconds(longint'(rsec));
                                t_preset = v[30:0];
                                t_count = rsec;
                                t_phase = PHASE_PAUSED;
                                t_overdue = 1'b0;
                            end
                        RS_ACTIVE:
                            if (t_phase == PHASE_PAUSED)
                            begin
                                t_phase = PHASE_RUNNING;
                                t_synced = sync_possible();
                                r.resumed = 1'b1;
                                r.from_remote = 1'b1;
                            end
                            else if (t_phase == PHASE_STOPPED)
                            begin
                                if (rsec == 0)
                                    rsec = {1'b0, t_preset};
                                start_count(longint'(rsec));
                                r.started = 1'b1;
                                r.from_remote = 1'b1;
                            end
                        default:
                            ;
                    endcase
                end
            REQ_REMOTE_REM:
                if (c_rr_present)
                begin
                    t_last_remote = c.rrem[31:8];
                    rsec = {8'd0, t_last_remote};
                    if (c_sync_en)
                    begin
                        t_synced = sync_possible();
                        since = c.stamp - t_last_sync;
                        if (c.rrem > HALF_SECOND_Q8 && rsec != 0)
                        begin
                            // stopped: adopt and run; otherwise a rate-limited resync
                            if (t_phase == PHASE_STOPPED)
                            begin
                                v = clamp_seconds(longint'(rsec));
                                t_preset = v[30:0];
                                t_count = rsec;
                                t_phase = PHASE_RUNNING;
                                t_overdue = 1'b0;
                            end
                            else if (since >= c_interval)
                            begin
                                t_count = rsec;
                                t_last_sync = c.stamp;
                            end
                        end
                    end
                end
            default:
                ;
        endcase
        r.count = t_count;
        r.preset = t_preset;
        if (t_phase == PHASE_STOPPED)
            r.status = ST_STOPPED;
        else if (t_phase == PHASE_PAUSED)
            r.status = ST_PAUSED;
        else
            r.status = t_overdue ? ST_RUNNING_OVERDUE : ST_RUNNING;
        r.overdue = t_overdue;
        r.synced = t_synced;
        return r;
    endfunction

    function automatic field_row_t as_fields(input timer_report_t r);
        field_row_t f;
        f[0] = r.count;
        f[1] = {1'b0, r.preset};
        f[2] = {30'd0, r.status};
        f[3] = {31'd0, r.overdue};
        f[4] = {31'd0, r.synced};
        f[5] = {31'd0, r.started};
        f[6] = {31'd0, r.paused};
        f[7] = {31'd0, r.resumed};
        f[8] = {31'd0, r.cancelled};
        f[9] = {31'd0, r.finished};
        f[10] = {31'd0, r.ticked};
        f[11] = {31'd0, r.from_remote};
        return f;
    endfunction

    function automatic timer_cmd_t cmd(input req_type_t k, input logic signed [31:0] s,
                                       input remote_state_t rs, input logic [31:0] rr,
                                       input logic [31:0] ms);
        timer_cmd_t c;
        c.kind = k;
        c.secs = s;
        c.rstate = rs;
        c.rrem = rr;
        c.stamp = ms;
        return c;
    endfunction

    function automatic logic signed [31:0] pick_seconds();
        int unsigned p;
        p = $urandom_range(0, 9);
        if (p < 6)
            return $urandom_range(0, 12);
        else if (p == 6)
            return $urandom | 32'h8000_0000;
        else if (p == 7)
            return 32'sh7FFF_FFFF;
        return $urandom;
    endfunction

    function automatic timer_cmd_t random_cmd();
        timer_cmd_t  c;
        int unsigned pick;
        int unsigned q;
        pick = $urandom_range(0, 99);
        c.kind = REQ_TICK;
        c.secs = $urandom;
        c.rstate = remote_state_t'($urandom_range(0, 3));
        c.rrem = $urandom;
        if ($urandom_range(0, 49) == 0)
            ms_clock = $urandom;
        else
            ms_clock = ms_clock + $urandom_range(0, 400);
        c.stamp = ms_clock;
        if (pick < 38)
            c.kind = REQ_TICK;
        else if (pick < 46)
        begin
            c.kind = REQ_START_VALUE;
            c.secs = pick_seconds();
        end
        else if (pick < 50)
            c.kind = REQ_START_PRESET;
        else if (pick < 54)
        begin
            c.kind = REQ_SET_PRESET;
            c.secs = pick_seconds();
        end
        else if (pick < 61)
            c.kind = REQ_PAUSE;
        else if (pick < 68)
            c.kind = REQ_RESUME;
        else if (pick < 72)
            c.kind = REQ_CANCEL;
        else if (pick < 83)
            c.kind = REQ_REMOTE_STATE;
        else if (pick < 96)
        begin
            c.kind = REQ_REMOTE_REM;
            q = $urandom_range(0, 9);
            if (q < 6)
                c.rrem = ($urandom_range(0, 15) << 8) | $urandom_range(0, 255);
            else if (q == 6)
                c.rrem = $urandom_range(0, 128);
            else if (q == 7)
                c.rrem = 32'hFFFF_FFFF;
        end
        else
            c.kind = req_type_t'($urandom_range(9, 15));
        return c;
    endfunction

    task automatic queue_cmd(input timer_cmd_t c);
        pending_cmds.push_back(c);
        cmds_queued++;
    endtask

    task automatic write_reg(input cfg_index_t idx, input cfg_data_t val);
        @(negedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data <= val;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        case (idx)
            CFG_MAX_DURATION:  c_max = val[23:0];
            CFG_SYNC_ENABLE:   c_sync_en = val[0];
            CFG_REMOTE_STATE:  c_rs_present = val[0];
            CFG_REMOTE_REM:    c_rr_present = val[0];
            CFG_SYNC_INTERVAL: c_interval = val;
            default:           ;
        endcase
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic apply_config(input logic [23:0] mx, input logic en, input logic srcs,
                                input logic srcr, input logic [31:0] intv);
        write_reg(CFG_MAX_DURATION, {8'd0, mx});
        write_reg(CFG_SYNC_ENABLE, {31'd0, en});
        write_reg(CFG_REMOTE_STATE, {31'd0, srcs});
        write_reg(CFG_REMOTE_REM, {31'd0, srcr});
        write_reg(CFG_SYNC_INTERVAL, intv);
    endtask

    // every report taken back, followed by a quiet spell
    task automatic wait_drained();
        while (reports_checked != cmds_queued)
            @(negedge clk);
        repeat (4)
            @(negedge clk);
    endtask

    always @(negedge clk)
    begin : req_drive
        timer_cmd_t nxt;
        if (!rst_n)
        begin
            req_ch.valid <= 1'b0;
            req_ch.req_type <= '0;
            req_ch.seconds_value <= '0;
            req_ch.remote_state <= '0;
            req_ch.remote_remaining <= '0;
            req_ch.now_ms <= '0;
        end
        else if (!req_ch.valid || reqs_accepted != reqs_seen)
        begin
            reqs_seen = reqs_accepted;
            if (pending_cmds.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
            begin
                nxt = pending_cmds.pop_front();
                req_ch.valid <= 1'b1;
                req_ch.req_type <= nxt.kind;
                req_ch.seconds_value <= nxt.secs;
                req_ch.remote_state <= nxt.rstate;
                req_ch.remote_remaining <= nxt.rrem;
                req_ch.now_ms <= nxt.stamp;
            end
            else
            begin
                req_ch.valid <= 1'b0;
            end
        end
    end

    always @(negedge clk)
    begin : rsp_stall
        rsp_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin : req_capture
        timer_cmd_t c;
        if (rst_n && req_ch.valid && req_ch.ready)
        begin
            c.kind = req_ch.req_type;
            c.secs = req_ch.seconds_value;
            c.rstate = req_ch.remote_state;
            c.rrem = req_ch.remote_remaining;
            c.stamp = req_ch.now_ms;
            predicted_reports.push_back(step_timer(c));
            reqs_accepted++;
        end
    end

    always @(posedge clk)
    begin : rsp_check
        timer_report_t got;
        timer_report_t want;
        field_row_t    gf;
        field_row_t    wf;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            got.count = rsp_ch.remaining_count;
            got.preset = rsp_ch.preset_count;
            got.status = rsp_ch.timer_status;
            got.overdue = rsp_ch.overdue_flag;
            got.synced = rsp_ch.synced_flag;
            got.started = rsp_ch.ev_started;
            got.paused = rsp_ch.ev_paused;
            got.resumed = rsp_ch.ev_resumed;
            got.cancelled = rsp_ch.ev_cancelled;
            got.finished = rsp_ch.ev_finished;
            got.ticked = rsp_ch.ev_ticked;
            got.from_remote = rsp_ch.ev_from_remote;
            gf = as_fields(got);
            if (predicted_reports.size() == 0)
            begin
                $display("%0t: unexpected report, expected none, got count %0h", $time, gf[0]);
                mismatch_count++;
            end
            else
            begin
                want = predicted_reports.pop_front();
                wf = as_fields(want);
                for (int i = 0; i < 12; i++)
                begin
                    if (gf[i] !== wf[i])
                    begin
                        $display("%0t: %s expected %0h got %0h", $time, field_names[i],
                                 wf[i], gf[i]);
                        mismatch_count++;
                    end
                end
                reports_checked++;
            end
        end
    end

    always @(posedge clk)
    begin : watchdog
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IdleLimit)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial
    begin : stimulus
        cfg_ch.valid = 1'b0;
        cfg_ch.index = '0;
        cfg_ch.data = '0;
        rst_n = 1'b0;
        repeat (10)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: clamps, idle commands, overdue, remote adopt and rate limit
        apply_config(24'd100, 1'b1, 1'b1, 1'b1, 32'd1000);
        queue_cmd(cmd(REQ_TICK, 0, RS_IDLE, 0, 0));
        queue_cmd(cmd(REQ_RESERVED, 0, RS_IDLE, 0, 0));
        queue_cmd(cmd(REQ_SET_PRESET, -32'sd5, RS_IDLE, 0, 0));
        queue_cmd(cmd(REQ_SET_PRESET, 32'sd1000, RS_IDLE, 0, 0));
        queue_cmd(cmd(REQ_SET_PRESET, 32'sd3, RS_IDLE, 0, 0));
        queue_cmd(cmd(REQ_START_PRESET, 0, RS_IDLE, 0, 0));
        queue_cmd(cmd(REQ_PAUSE, 0, RS_IDLE, 0, 0));
        queue_cmd(cmd(REQ_PAUSE, 0, RS_IDLE, 0, 0));
        queue_cmd(cmd(REQ_RESUME, 0, RS_IDLE, 0, 0));
        queue_cmd(cmd(REQ_RESUME, 0, RS_IDLE, 0, 0));
        repeat (4)
            queue_cmd(cmd(REQ_TICK, 0, RS_IDLE, 0, 0));
        queue_cmd(cmd(REQ_START_VALUE, 32'sh7FFF_FFFF, RS_IDLE, 0, 0));
        queue_cmd(cmd(REQ_START_VALUE, MIN_COUNT, RS_IDLE, 0, 0));
        queue_cmd(cmd(REQ_TICK, 0, RS_IDLE, 0, 0));
        queue_cmd(cmd(REQ_CANCEL, 0, RS_IDLE, 0, 0));
        queue_cmd(cmd(REQ_REMOTE_REM, 0, RS_IDLE, HALF_SECOND_Q8, 32'd0));
        queue_cmd(cmd(REQ_REMOTE_REM, 0, RS_IDLE, 32'h0000_0500, 32'd0));
        queue_cmd(cmd(REQ_REMOTE_REM, 0, RS_IDLE, 32'h0000_0900, 32'd500));
        queue_cmd(cmd(REQ_REMOTE_REM, 0, RS_IDLE, 32'h0000_0900, 32'd1500));
        queue_cmd(cmd(REQ_REMOTE_STATE, 0, RS_PAUSED, 0, 0));
        queue_cmd(cmd(REQ_REMOTE_STATE, 0, RS_ACTIVE, 0, 0));
        queue_cmd(cmd(REQ_REMOTE_STATE, 0, RS_IDLE, 0, 0));
        queue_cmd(cmd(REQ_REMOTE_STATE, 0, RS_ACTIVE, 0, 0));
        queue_cmd(cmd(REQ_REMOTE_REM, 0, RS_OTHER, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        wait_drained();

        for (int ph = 0; ph < 8; ph++)
        begin
            case (ph)
                0: apply_config(24'hFF_FFFF, 1'b1, 1'b1, 1'b1, 32'd0);
                1: apply_config(24'd20, 1'b1, 1'b1, 1'b1, 32'd500);
                2: apply_config(24'd0, 1'b0, 1'b1, 1'b1, 32'd300);
                3: apply_config(24'd7, 1'b1, 1'b0, 1'b1, 32'hFFFF_FFFF);
                4: apply_config(24'd100, 1'b1, 1'b1, 1'b0, 32'd1000);
                5: apply_config(24'd0, 1'b1, 1'b1, 1'b1, 32'd200);
                6: apply_config(24'hFF_FFFF, 1'b0, 1'b0, 1'b0, 32'd0);
                default: apply_config(24'($urandom_range(1, 30)), 1'b1, 1'b1, 1'b1,
                                      $urandom_range(0, 2000));
            endcase
            case (ph % 4)
                0:
                begin
                    send_idle_pct = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct = 56;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    recv_stall_pct = 56;
                end
                default:
                begin
                    send_idle_pct = 20;
                    recv_stall_pct = 20;
                end
            endcase
            repeat (110)
                queue_cmd(random_cmd());
            wait_drained();
        end

        if (mismatch_count == 0 && predicted_reports.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
